// ----- rtl/ccur_pkg.sv -----
// shared types and constants of the text console cursor engine
package ccur_pkg;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CURSOR_ON  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STORE_ON   = 3'd5;

    localparam logic [1:0] KIND_DRAW   = 2'd0;
    localparam logic [1:0] KIND_REDRAW = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    localparam logic [7:0]  CH_BACKSPACE = 8'h08;
    localparam logic [7:0]  CH_TAB       = 8'h09;
    localparam logic [7:0]  CH_NEWLINE   = 8'h0a;
    localparam logic [7:0]  CH_SPACE     = 8'h20;
    localparam logic [7:0]  CH_PRINT_LO  = 8'h20;
    localparam logic [7:0]  CH_PRINT_HI  = 8'h7f;
    localparam logic [31:0] ERASE_FORE   = 32'h00ff_ffff;
    localparam int          TAB_STEP     = 8;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_READ,
        OP_BS,
        OP_TAB,
        OP_NL,
        OP_PRINT
    } t_op;

    typedef struct packed {
        logic        mode;
        logic [7:0]  char_code;
        logic [12:0] cell_index;
    } t_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  cell_col;
        logic [5:0]  cell_row;
        logic [7:0]  glyph_code;
        logic [31:0] fore;
        logic [31:0] back;
        logic        last;
    } t_res;

    typedef struct packed {
        t_op         op;
        logic [7:0]  char_code;
        logic [12:0] cell_index;
    } t_cmd;

    typedef struct packed {
        logic [7:0]  columns;
        logic [6:0]  rows;
        logic [31:0] text_color;
        logic [31:0] back_color;
        logic        cursor_on;
        logic        store_on;
    } t_cfg;

endpackage

// ----- rtl/text_console_cursor_engine_unit.sv -----
// top level of the text console cursor engine
//
//  channel  | handshake          | payload | direction
//  ---------+--------------------+---------+----------
//  request  | push / full        | i_req   | in
//  result   | pop / empty        | o_res   | out
//  config   | i_cfg_we           | i_cfg_idx, i_cfg_data | in
//
// the sequencer takes the next request only once the current one, scroll included, is done
// a scroll moves the stored cells up one row and blanks the last two rows
// reset starts a clearing pass over all MAX_COLS*MAX_ROWS cells of the cell store;
// requests queue up meanwhile but are not carried out
// the request queue holds 2 requests, the result queue 4 results, so both
// sides stall independently of the sequencer
module text_console_cursor_engine_unit import ccur_pkg::*; #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  t_req                 i_req,
    output logic                 empty,
    input  logic                 pop,
    output t_res                 o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data
);
    // configuration registers
    t_cfg r_cfg;

    // front side to command queue
    logic q_push, q_full, q_empty, q_pop;
    t_cmd q_in, q_out;

    // sequencer to result queue
    logic res_push, res_full;
    t_res res_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.columns    <= 8'd80;
            r_cfg.rows       <= 7'd25;
            r_cfg.text_color <= 32'h00ff_ffff;
            r_cfg.back_color <= 32'h0;
            r_cfg.cursor_on  <= 1'b1;
            r_cfg.store_on   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_COLUMNS:    r_cfg.columns    <= i_cfg_data[7:0];
                REG_ROWS:       r_cfg.rows       <= i_cfg_data[6:0];
                REG_TEXT_COLOR: r_cfg.text_color <= i_cfg_data;
                REG_BACK_COLOR: r_cfg.back_color <= i_cfg_data;
                REG_CURSOR_ON:  r_cfg.cursor_on  <= i_cfg_data[0];
                REG_STORE_ON:   r_cfg.store_on   <= i_cfg_data[0];
                default: begin
                    // unknown register index, write dropped
                end
            endcase
        end
    end

    // classify incoming requests
    ccur_front u_front (
        .i_push   (push),
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_full   (full),
        .o_q_push (q_push),
        .o_cmd    (q_in)
    );

    // decoupling queue between classifier and sequencer
    ccur_fifo #(
        .W     ($bits(t_cmd)),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    // cursor, cell store and scroll sequencer
    ccur_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (!q_empty),
        .i_cmd       (q_out),
        .o_cmd_pop   (q_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // result queue, oldest result on o_res
    ccur_fifo #(
        .W     ($bits(t_res)),
        .DEPTH (4)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_res)
    );
endmodule

// ----- rtl/ccur_fifo.sv -----
// small register queue
module ccur_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic          push_ok, pop_ok;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= (r_wp == PW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= (r_rp == PW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!push_ok && pop_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

// ----- rtl/ccur_front.sv -----
// request classifier in front of the command queue
module ccur_front import ccur_pkg::*; (
    input  logic i_push,
    input  t_req i_req,
    input  logic i_q_full,
    output logic o_full,
    output logic o_q_push,
    output t_cmd o_cmd
);
    t_op op;

    always_comb begin
        if (i_req.mode) begin
            op = OP_READ;
        end else if (i_req.char_code == CH_BACKSPACE) begin
            op = OP_BS;
        end else if (i_req.char_code == CH_TAB) begin
            op = OP_TAB;
        end else if (i_req.char_code == CH_NEWLINE) begin
            op = OP_NL;
        end else if (i_req.char_code >= CH_PRINT_LO && i_req.char_code <= CH_PRINT_HI) begin
            op = OP_PRINT;
        end else begin
            op = OP_NONE;
        end
    end

    assign o_full           = i_q_full;
    assign o_q_push         = i_push && !i_q_full;
    assign o_cmd.op         = op;
    assign o_cmd.char_code  = i_req.char_code;
    assign o_cmd.cell_index = i_req.cell_index;
endmodule

// ----- rtl/ccur_back.sv -----
// command sequencer: cursor, cell store, scroll and result generation
module ccur_back import ccur_pkg::*; #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    input  logic i_res_full,
    output logic o_res_push,
    output t_res o_res
);
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = AW + 1;
    localparam int CW    = $clog2(MAX_COLS + TAB_STEP);
    localparam int RW    = $clog2(MAX_ROWS + 2);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_CHAR, S_EMIT1, S_COPY, S_CLR, S_REDRAW, S_CURSOR, S_RD1, S_RD2
    } t_state;

    logic [7:0] r_store [DEPTH];

    t_state        r_state;
    t_cmd          r_cmd;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          r_scroll, r_pv, r_oob;
    t_res          r_e1;
    logic [NW-1:0] r_saddr, r_lim, r_cnt;
    logic [AW-1:0] r_pa;
    logic [7:0]    r_rdata;

    logic [CW-1:0] cols, c_col;
    logic [RW-1:0] rws, c_row;
    logic          c_draw1, c_scroll, c_print;
    logic          mem_we, mem_re, issue;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [7:0]    mem_wd;

    // geometry saturated to the supported range
    always_comb begin
        if (i_cfg.columns < 8'd2) begin
            cols = CW'(2);
        end else if (32'(i_cfg.columns) > 32'(MAX_COLS)) begin
            cols = CW'(MAX_COLS);
        end else begin
            cols = CW'(i_cfg.columns);
        end
        if (i_cfg.rows < 7'd3) begin
            rws = RW'(3);
        end else if (32'(i_cfg.rows) > 32'(MAX_ROWS)) begin
            rws = RW'(MAX_ROWS);
        end else begin
            rws = RW'(i_cfg.rows);
        end
    end

    // cursor move for the current character
    always_comb begin
        c_col    = r_col;
        c_row    = r_row;
        c_scroll = 1'b0;
        c_print  = (r_cmd.op == OP_PRINT);
        c_draw1  = (r_cmd.op == OP_NL) || c_print || (r_cmd.op == OP_BS && r_col != '0);
        unique case (r_cmd.op)
            OP_BS: begin
                if (r_col != '0) begin
                    c_col = r_col - 1'b1;
                end
            end
            OP_TAB: begin
                c_col = (r_col + CW'(TAB_STEP)) & ~CW'(TAB_STEP - 1);
            end
            OP_NL: begin
                c_col = '0;
                c_row = r_row + 1'b1;
            end
            OP_PRINT: begin
                c_col = r_col + 1'b1;
            end
            OP_NONE, OP_READ: begin
            end
            default: begin
            end
        endcase
        if (c_col >= cols) begin
            c_col = '0;
            c_row = c_row + 1'b1;
        end
        if (c_row >= rws - 1'b1) begin
            if (i_cfg.store_on) begin
                c_scroll = 1'b1;
                c_row    = rws - RW'(2);
            end else begin
                c_col = '0;
                c_row = '0;
            end
        end
    end

    assign issue = (r_cnt < r_lim);

    // store port control
    always_comb begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '0;
        mem_re = 1'b0;
        mem_ra = '0;
        unique case (r_state)
            S_INIT: begin
                mem_we = 1'b1;
                mem_wa = AW'(r_cnt);
            end
            S_EMIT1: begin
                mem_we = !i_res_full && i_cfg.store_on && (r_cmd.op == OP_PRINT);
                mem_wa = AW'(r_saddr);
                mem_wd = r_cmd.char_code;
            end
            S_COPY: begin
                mem_re = issue;
                mem_ra = AW'(r_cnt + NW'(cols));
                mem_we = r_pv;
                mem_wa = r_pa;
                mem_wd = r_rdata;
            end
            S_CLR: begin
                mem_we = 1'b1;
                mem_wa = AW'(r_cnt);
            end
            S_RD1: begin
                mem_re = 1'b1;
                mem_ra = AW'(r_cmd.cell_index);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_store[mem_ra];
        end
    end

    // result selection
    always_comb begin
        o_res_push = 1'b0;
        o_res      = '0;
        unique case (r_state)
            S_EMIT1: begin
                o_res_push = !i_res_full;
                o_res      = r_e1;
            end
            S_REDRAW: begin
                o_res_push = !i_res_full;
                o_res.kind = KIND_REDRAW;
                o_res.fore = i_cfg.text_color;
                o_res.back = i_cfg.back_color;
                o_res.last = !i_cfg.cursor_on;
            end
            S_CURSOR: begin
                o_res_push       = !i_res_full && i_cfg.cursor_on;
                o_res.kind       = KIND_DRAW;
                o_res.cell_col   = 7'(r_col);
                o_res.cell_row   = 6'(r_row);
                o_res.glyph_code = CH_SPACE;
                o_res.fore       = i_cfg.back_color;
                o_res.back       = i_cfg.text_color;
                o_res.last       = 1'b1;
            end
            S_RD2: begin
                o_res_push       = !i_res_full;
                o_res.kind       = KIND_READ;
                o_res.glyph_code = r_oob ? 8'h00 : r_rdata;
                o_res.last       = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_pv    <= 1'b0;
        end else begin
            unique case (r_state)
                S_INIT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == NW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        if (i_cmd.op == OP_READ) begin
                            r_state <= S_RD1;
                        end else begin
                            if (r_col >= cols) begin
                                r_col <= cols - 1'b1;
                            end
                            if (r_row >= rws) begin
                                r_row <= rws - 1'b1;
                            end
                            r_state <= S_CHAR;
                        end
                    end
                end
                S_CHAR: begin
                    r_col    <= c_col;
                    r_row    <= c_row;
                    r_scroll <= c_scroll;
                    r_saddr  <= NW'(NW'(r_row) * NW'(cols) + NW'(r_col));
                    r_lim    <= NW'(NW'(rws - 1'b1) * NW'(cols));
                    r_cnt    <= '0;
                    r_pv     <= 1'b0;
                    r_e1.kind       <= KIND_DRAW;
                    r_e1.cell_col   <= 7'(r_col);
                    r_e1.cell_row   <= 6'(r_row);
                    r_e1.glyph_code <= c_print ? r_cmd.char_code : CH_SPACE;
                    r_e1.fore       <= c_print ? i_cfg.text_color : ERASE_FORE;
                    r_e1.back       <= c_print ? i_cfg.back_color : 32'h0;
                    r_e1.last       <= !c_scroll && !i_cfg.cursor_on;
                    if (c_draw1) begin
                        r_state <= S_EMIT1;
                    end else if (c_scroll) begin
                        r_state <= S_COPY;
                    end else begin
                        r_state <= S_CURSOR;
                    end
                end
                S_EMIT1: begin
                    if (!i_res_full) begin
                        r_state <= r_scroll ? S_COPY : S_CURSOR;
                    end
                end
                S_COPY: begin
                    // read one row ahead, write back in the next cycle
                    r_pv <= issue;
                    r_pa <= AW'(r_cnt);
                    if (issue) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else if (!r_pv) begin
                        r_cnt   <= r_lim - NW'(cols);
                        r_state <= S_CLR;
                    end
                end
                S_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt + 1'b1 == r_lim + NW'(cols)) begin
                        r_state <= S_REDRAW;
                    end
                end
                S_REDRAW: begin
                    if (!i_res_full) begin
                        r_state <= S_CURSOR;
                    end
                end
                S_CURSOR: begin
                    if (!i_cfg.cursor_on || !i_res_full) begin
                        r_state <= S_IDLE;
                    end
                end
                S_RD1: begin
                    r_oob   <= (32'(r_cmd.cell_index) >= 32'(DEPTH));
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    if (!i_res_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ----- rtl/ccur_checker.sv -----
// port checker for the text console cursor engine and its binding
module ccur_checker import ccur_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic pop,
    input logic empty,
    input t_res o_res
);
    // reset flushes all waiting results
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("results left after reset");

    // a read result carries no position and no colors and ends its request
    a_read_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.kind == KIND_READ) |->
        (o_res.fore == 32'h0 && o_res.back == 32'h0 && o_res.last
         && o_res.cell_col == 7'h0 && o_res.cell_row == 6'h0))
        else $error("bad read result");

    // a redraw result has no cell position or glyph
    a_redraw_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.kind == KIND_REDRAW) |->
        (o_res.cell_col == 7'h0 && o_res.cell_row == 6'h0 && o_res.glyph_code == 8'h0))
        else $error("bad redraw result");

    // a waiting result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_res)))
        else $error("result changed while waiting");
endmodule

bind text_console_cursor_engine_unit ccur_checker u_ccur_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .pop     (pop),
    .empty   (empty),
    .o_res   (o_res)
);

// ----- tb/sv/tb_text_console_cursor_engine_unit.sv -----
// self-checking testbench of the text console cursor engine unit
module tb_text_console_cursor_engine_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import ccur_pkg::*;

    localparam int MAX_COLS    = 128;
    localparam int MAX_ROWS    = 64;
    localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int HOLD_CYCLES = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_req        i_req;
    logic        empty;
    logic        pop;
    t_res        o_res;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    text_console_cursor_engine_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_req      (i_req),
        .empty      (empty),
        .pop        (pop),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // console shadow: registers, cursor and cell store
    logic [7:0]  sh_columns;
    logic [6:0]  sh_rows;
    logic [31:0] sh_text_color;
    logic [31:0] sh_back_color;
    logic        sh_cursor_on;
    logic        sh_store_on;
    int          cur_col;
    int          cur_row;
    logic [7:0]  cell_shadow [STORE_DEPTH];

    t_req pending_reqs [$];
    t_res expected_cells [$];

    int  mismatches;
    int  requests_taken;
    int  results_checked;
    int  scrolls_seen;
    int  cycles;
    bit  idle_on;
    bit  hold_done;
    int  hold_left;
    int  send_gap;
    int  pop_gap;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_res mk_cell(logic [1:0] kind, int col, int row, logic [7:0] glyph,
                                      logic [31:0] fg, logic [31:0] bg);
        t_res r;
        r = '0;
        r.kind       = kind;
        r.cell_col   = col[6:0];
        r.cell_row   = row[5:0];
        r.glyph_code = glyph;
        r.fore       = fg;
        r.back       = bg;
        return r;
    endfunction

    function automatic int geo_cols();
        int c;
        c = sh_columns;
        return c < 2 ? 2 : (c > MAX_COLS ? MAX_COLS : c);
    endfunction

    function automatic int geo_rows();
        int r;
        r = sh_rows;
        return r < 3 ? 3 : (r > MAX_ROWS ? MAX_ROWS : r);
    endfunction

    // works out the cells that one request draws and updates the shadow console
    task automatic console_step(input t_req r);
        t_res cells [$];
        t_res e;
        int   c;
        int   rw;
        logic [7:0] ch;
        ch = r.char_code;
        if (r.mode) begin
            e = mk_cell(KIND_READ, 0, 0, cell_shadow[r.cell_index], 0, 0);
            e.last = 1'b1;
            expected_cells.push_back(e);
            return;
        end
        c  = geo_cols();
        rw = geo_rows();
        // cursor left outside by a geometry change is pulled back in
        if (cur_col >= c) cur_col = c - 1;
        if (cur_row >= rw) cur_row = rw - 1;

        if (ch == CH_BACKSPACE && cur_col != 0) begin
            cells.push_back(mk_cell(KIND_DRAW, cur_col, cur_row, CH_SPACE, ERASE_FORE, 0));
            cur_col--;
        end else if (ch == CH_TAB) begin
            cur_col = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
        end else if (ch == CH_NEWLINE) begin
            cells.push_back(mk_cell(KIND_DRAW, cur_col, cur_row, CH_SPACE, ERASE_FORE, 0));
            cur_col = 0;
            cur_row++;
        end
        if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
            cells.push_back(mk_cell(KIND_DRAW, cur_col, cur_row, ch,
                                    sh_text_color, sh_back_color));
            if (sh_store_on) cell_shadow[cur_row * c + cur_col] = ch;
            cur_col++;
        end
        if (cur_col >= c) begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= rw - 1) begin
            if (!sh_store_on) begin
                cur_col = 0;
                cur_row = 0;
            end else begin
                // shift up one row, blank the last two
                for (int i = 0; i < (rw - 1) * c; i++) cell_shadow[i] = cell_shadow[i + c];
                for (int i = (rw - 2) * c; i < rw * c; i++) cell_shadow[i] = 8'h00;
                cur_row = rw - 2;
                scrolls_seen++;
                cells.push_back(mk_cell(KIND_REDRAW, 0, 0, 8'h00,
                                        sh_text_color, sh_back_color));
            end
        end
        if (sh_cursor_on)
            cells.push_back(mk_cell(KIND_DRAW, cur_col, cur_row, CH_SPACE,
                                    sh_back_color, sh_text_color));
        if (cells.size() > 0) cells[cells.size()-1].last = 1'b1;
        foreach (cells[k]) expected_cells.push_back(cells[k]);
    endtask

    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (!idle_on || p < 60) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // request side: acceptance seen at the rising edge, new request set up at the falling one
    bit taken;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        taken  <= i_rst_n && push && !full;
        if (i_rst_n && push && !full) begin
            console_step(i_req);
            requests_taken <= requests_taken + 1;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && !(push && !taken)) begin
            if (send_gap > 0) begin
                push     <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_reqs.size() > 0) begin
                push     <= 1'b1;
                i_req    <= pending_reqs.pop_front();
                send_gap <= pick_gap();
            end else begin
                push <= 1'b0;
            end
        end
    end

    // result side: random pop gaps plus one long hold-off to fill the block
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!hold_done && results_checked == 30) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                pop       <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                pop       <= 1'b0;
            end else if (pop_gap > 0) begin
                pop_gap <= pop_gap - 1;
                pop     <= 1'b0;
            end else begin
                pop     <= 1'b1;
                pop_gap <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && pop && !empty) begin
            results_checked <= results_checked + 1;
            if (expected_cells.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result %p", o_res);
            end else begin
                want = expected_cells.pop_front();
                if (o_res !== want) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("result mismatch: expected %p got %p", want, o_res);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_text_console_cursor_engine_unit NOT OK");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        case (idx)
            REG_COLUMNS:    sh_columns    = value[7:0];
            REG_ROWS:       sh_rows       = value[6:0];
            REG_TEXT_COLOR: sh_text_color = value;
            REG_BACK_COLOR: sh_back_color = value;
            REG_CURSOR_ON:  sh_cursor_on  = value[0];
            REG_STORE_ON:   sh_store_on   = value[0];
            default: ;
        endcase
    endtask

    // wait for every request to drain, then cover a scroll that ends silently
    task automatic drain();
        wait (pending_reqs.size() == 0 && !push && expected_cells.size() == 0);
        repeat ((geo_rows() + 1) * geo_cols() + 50) @(posedge i_clk);
    endtask

    function automatic t_req put_req(logic [7:0] ch);
        t_req r;
        r.mode       = 1'b0;
        r.char_code  = ch;
        r.cell_index = 13'($urandom);
        return r;
    endfunction

    function automatic t_req read_req(logic [12:0] idx);
        t_req r;
        r.mode       = 1'b1;
        r.char_code  = 8'($urandom);
        r.cell_index = idx;
        return r;
    endfunction

    function automatic t_req random_req();
        int p;
        p = $urandom_range(99);
        if (p < 55) return put_req(8'($urandom_range(CH_PRINT_HI, CH_PRINT_LO)));
        if (p < 67) return put_req(CH_NEWLINE);
        if (p < 73) return put_req(CH_TAB);
        if (p < 81) return put_req(CH_BACKSPACE);
        if (p < 86) return put_req(8'($urandom));
        if (p < 93) return read_req(13'($urandom_range(geo_rows() * geo_cols() - 1)));
        return read_req(13'($urandom));
    endfunction

    task automatic run_phase(input logic [7:0] cols, input logic [6:0] rws,
                             input logic [31:0] fg, input logic [31:0] bg,
                             input bit cur, input bit st, input int count);
        drain();
        write_reg(REG_COLUMNS, cols);
        write_reg(REG_ROWS, rws);
        write_reg(REG_TEXT_COLOR, fg);
        write_reg(REG_BACK_COLOR, bg);
        write_reg(REG_CURSOR_ON, cur);
        write_reg(REG_STORE_ON, st);
        idle_on = ~idle_on;
        repeat (count) pending_reqs.push_back(random_req());
    endtask

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_req = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_COLUMNS;
        i_cfg_data = '0;
        cycles = 0;
        mismatches = 0;
        requests_taken = 0;
        results_checked = 0;
        scrolls_seen = 0;
        send_gap = 0;
        pop_gap = 0;
        hold_left = 0;
        hold_done = 1'b0;
        idle_on = 1'b1;
        taken = 1'b0;
        sh_columns = 8'd80;
        sh_rows = 7'd25;
        sh_text_color = ERASE_FORE;
        sh_back_color = '0;
        sh_cursor_on = 1'b1;
        sh_store_on = 1'b1;
        cur_col = 0;
        cur_row = 0;
        foreach (cell_shadow[i]) cell_shadow[i] = 8'h00;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: printable extremes, ignored codes, controls mid-line and at column zero, reads
        pending_reqs.push_back(put_req("A"));
        pending_reqs.push_back(put_req(CH_PRINT_LO));
        pending_reqs.push_back(put_req(CH_PRINT_HI));
        pending_reqs.push_back(put_req(8'h80));
        pending_reqs.push_back(put_req(8'hff));
        pending_reqs.push_back(put_req(8'h00));
        pending_reqs.push_back(put_req(CH_BACKSPACE));
        pending_reqs.push_back(put_req(CH_TAB));
        pending_reqs.push_back(put_req(CH_TAB));
        pending_reqs.push_back(put_req("z"));
        pending_reqs.push_back(put_req(CH_NEWLINE));
        pending_reqs.push_back(put_req(CH_BACKSPACE));
        pending_reqs.push_back(read_req(13'd0));
        pending_reqs.push_back(read_req(13'd2));
        pending_reqs.push_back(read_req(13'd3));
        pending_reqs.push_back(read_req(13'h1fff));
        pending_reqs.push_back(read_req(13'h0aaa));
        pending_reqs.push_back(read_req(13'h1555));
        pending_reqs.push_back(put_req(8'h55));
        pending_reqs.push_back(put_req(8'h2a));

        // smallest screen: wraps and scrolls every few characters
        run_phase(8'd2, 7'd3, 32'h0, 32'hffff_ffff, 1'b1, 1'b1, 20);
        run_phase(8'd128, 7'd64, 32'($urandom), 32'($urandom), 1'b1, 1'b1, 20);
        // cursor now outside the small geometry, register values below range
        run_phase(8'd0, 7'd0, 32'($urandom), 32'($urandom), 1'b0, 1'b1, 20);
        run_phase(8'd255, 7'd127, 32'hffff_ffff, 32'h0, 1'b0, 1'b0, 15);
        run_phase(8'd10, 7'd5, 32'($urandom), 32'($urandom), 1'b1, 1'b0, 20);
        run_phase(8'd7, 7'd4, 32'($urandom), 32'($urandom), 1'b0, 1'b1, 20);
        run_phase(8'd200, 7'd9, 32'($urandom), 32'($urandom), 1'b1, 1'b1, 20);
        run_phase(8'd16, 7'd6, 32'($urandom), 32'($urandom),
                  1'($urandom), 1'($urandom), 25);
        drain();

        $display("run covered %0d requests, %0d results checked, %0d scrolls, %0d mismatches",
                 requests_taken, results_checked, scrolls_seen, mismatches);
        if (mismatches == 0 && expected_cells.size() == 0) begin
            $display("tb_text_console_cursor_engine_unit OK");
        end else begin
            $display("tb_text_console_cursor_engine_unit NOT OK");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ccur_pkg.sv
rtl/ccur_fifo.sv
rtl/ccur_front.sv
rtl/ccur_back.sv
rtl/text_console_cursor_engine_unit.sv
rtl/ccur_checker.sv
tb/sv/tb_text_console_cursor_engine_unit.sv
